>>> rtl/ptstc_pkg.sv
// Package with types and constants shared by the pan/tilt search-and-track controller.
`timescale 1ns / 1ps
`default_nettype none

package ptstc_pkg;

    localparam int PAN_W   = 12;
    localparam int TILT_W  = 10;
    localparam int TICK_W  = 16;
    localparam int PIX_W   = 10;
    localparam int CONF_W  = 8;
    localparam int GAIN_W  = 12;
    localparam int STEP_W  = 8;
    localparam int CORR_W  = 14;
    localparam int SUM_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Head geometry in milliradians.
    localparam int PAN_LIMIT_MRAD = 1496;
    localparam int TILT_LOW_MRAD  = 500;
    localparam int TILT_HIGH_MRAD = 700;
    localparam int TILT_STEP_MRAD = 100;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_EXTRA = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONF_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AIM_X      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_AIM_Y      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_STEP   = 3'd7;

    typedef enum logic [1:0] {
        MODE_SEARCH = 2'd0,
        MODE_TRACK  = 2'd1,
        MODE_LOST   = 2'd2
    } mode_t;

    typedef struct packed {
        logic              kind;
        logic [PIX_W-1:0]  obj_x;
        logic [PIX_W-1:0]  obj_y;
        logic [CONF_W-1:0] confidence;
    } in_t;

    typedef struct packed {
        logic signed [PAN_W-1:0] pan_goal;
        logic [TILT_W-1:0]       tilt_goal;
        logic                    from_search;
        logic [1:0]              mode;
    } out_t;

    typedef struct packed {
        logic [TICK_W-1:0] timeout_ticks;
        logic [TICK_W-1:0] lost_extra_ticks;
        logic [CONF_W-1:0] confidence_threshold;
        logic [GAIN_W-1:0] pan_gain;
        logic [GAIN_W-1:0] tilt_gain;
        logic [PIX_W-1:0]  aim_x;
        logic [PIX_W-1:0]  aim_y;
        logic [STEP_W-1:0] pan_step;
    } cfg_t;

    // One item after the front stage: pixel corrections already rounded to milliradians.
    typedef struct packed {
        logic                     kind;
        logic                     corr_en;
        logic signed [CORR_W-1:0] pan_corr;
        logic signed [CORR_W-1:0] tilt_corr;
    } item_t;

endpackage

`default_nettype wire

>>> rtl/ptstc_cfg.sv
// Configuration register bank of the pan/tilt controller.
`timescale 1ns / 1ps
`default_nettype none

module ptstc_cfg
    import ptstc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ticks        <= TICK_W'(50);
            cfg_reg.lost_extra_ticks     <= TICK_W'(30);
            cfg_reg.confidence_threshold <= CONF_W'(204);
            cfg_reg.pan_gain             <= GAIN_W'(160);
            cfg_reg.tilt_gain            <= GAIN_W'(107);
            cfg_reg.aim_x                <= PIX_W'(320);
            cfg_reg.aim_y                <= PIX_W'(240);
            cfg_reg.pan_step             <= STEP_W'(50);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TIMEOUT:    cfg_reg.timeout_ticks        <= cfg_data[TICK_W-1:0];
                CFG_LOST_EXTRA: cfg_reg.lost_extra_ticks     <= cfg_data[TICK_W-1:0];
                CFG_CONF_THR:   cfg_reg.confidence_threshold <= cfg_data[CONF_W-1:0];
                CFG_PAN_GAIN:   cfg_reg.pan_gain             <= cfg_data[GAIN_W-1:0];
                CFG_TILT_GAIN:  cfg_reg.tilt_gain            <= cfg_data[GAIN_W-1:0];
                CFG_AIM_X:      cfg_reg.aim_x                <= cfg_data[PIX_W-1:0];
                CFG_AIM_Y:      cfg_reg.aim_y                <= cfg_data[PIX_W-1:0];
                CFG_PAN_STEP:   cfg_reg.pan_step             <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/ptstc_front.sv
// Input register stage: takes a transaction and forms the rounded pixel-error corrections.
`timescale 1ns / 1ps
`default_nettype none

module ptstc_front
    import ptstc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire in_t   s_data,
    input  wire cfg_t  cfg,
    input  wire logic  advance,
    output logic       item_valid,
    output item_t      item
);

    localparam int ERR_W  = PIX_W + 1;
    localparam int PROD_W = 24;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    logic signed [ERR_W-1:0]  ex;
    logic signed [ERR_W-1:0]  ey;
    logic signed [PROD_W-1:0] pan_prod;
    logic signed [PROD_W-1:0] tilt_prod;
    logic signed [PROD_W-1:0] pan_rnd;
    logic signed [PROD_W-1:0] tilt_rnd;

    always_comb begin
        ex = signed'({1'b0, s_data.obj_x}) - signed'({1'b0, cfg.aim_x});
        ey = signed'({1'b0, s_data.obj_y}) - signed'({1'b0, cfg.aim_y});
        pan_prod  = -(PROD_W'(signed'({1'b0, cfg.pan_gain})) * PROD_W'(ex));
        tilt_prod = PROD_W'(signed'({1'b0, cfg.tilt_gain})) * PROD_W'(ey);
        // Adding half an LSB and shifting right rounds to nearest with halves going up.
        pan_rnd  = pan_prod + PROD_W'(512);
        tilt_rnd = tilt_prod + PROD_W'(512);
        item_next.kind      = s_data.kind;
        item_next.corr_en   = s_data.confidence > cfg.confidence_threshold;
        item_next.pan_corr  = pan_rnd[PROD_W-1:10];
        item_next.tilt_corr = tilt_rnd[PROD_W-1:10];
    end

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ptstc_core.sv
// Mode, sweep and goal state update with the result register.
`timescale 1ns / 1ps
`default_nettype none

module ptstc_core
    import ptstc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cfg_t  cfg,
    input  wire logic  item_valid,
    input  wire item_t item,
    output logic       advance,
    output logic       m_valid,
    input  wire logic  m_ready,
    output out_t       m_data
);

    localparam int SP_W = PAN_W + 1;
    localparam int ST_W = TILT_W + 1;

    mode_t                   mode_reg,    mode_next;
    logic [TICK_W-1:0]       ticks_reg,   ticks_next;
    logic signed [PAN_W-1:0] sweep_pan_reg, sweep_pan_next;
    logic [TILT_W-1:0]       sweep_tilt_reg, sweep_tilt_next;
    logic                    rising_reg,  rising_next;
    logic signed [PAN_W-1:0] goal_pan_reg, goal_pan_next;
    logic [TILT_W-1:0]       goal_tilt_reg, goal_tilt_next;
    logic                    m_valid_reg;
    out_t                    m_data_reg;

    logic                    has_result;
    logic                    from_search;
    logic [TICK_W-1:0]       tick_inc;
    logic                    timed_out;
    logic                    lost_done;
    logic signed [SP_W-1:0]  sp_sum;
    logic signed [PAN_W-1:0] sw_pan;
    logic                    sw_rising;
    logic                    at_end;
    logic [ST_W-1:0]         st_sum;
    logic [TILT_W-1:0]       sw_tilt;
    logic signed [SUM_W-1:0] pan_sum;
    logic signed [SUM_W-1:0] tilt_sum;
    logic signed [PAN_W-1:0] pan_clamped;
    logic [TILT_W-1:0]       tilt_clamped;

    always_comb begin
        tick_inc  = (ticks_reg != '1) ? ticks_reg + TICK_W'(1) : ticks_reg;
        timed_out = tick_inc > cfg.timeout_ticks;
        lost_done = {1'b0, tick_inc} >
                    ({1'b0, cfg.timeout_ticks} + {1'b0, cfg.lost_extra_ticks});

        // One step of the back-and-forth sweep; an end of travel flips direction and steps the tilt.
        if (rising_reg) begin
            sp_sum = SP_W'(sweep_pan_reg) + SP_W'({1'b0, cfg.pan_step});
            at_end = sp_sum >= SP_W'(PAN_LIMIT_MRAD);
        end else begin
            sp_sum = SP_W'(sweep_pan_reg) - SP_W'({1'b0, cfg.pan_step});
            at_end = sp_sum <= -SP_W'(PAN_LIMIT_MRAD);
        end
        if (at_end) begin
            sw_pan    = rising_reg ? PAN_W'(PAN_LIMIT_MRAD) : -PAN_W'(PAN_LIMIT_MRAD);
            sw_rising = !rising_reg;
        end else begin
            sw_pan    = sp_sum[PAN_W-1:0];
            sw_rising = rising_reg;
        end
        if (at_end && (sweep_tilt_reg < TILT_W'(TILT_HIGH_MRAD))) begin
            st_sum = {1'b0, sweep_tilt_reg} + ST_W'(TILT_STEP_MRAD);
        end else begin
            st_sum = {1'b0, sweep_tilt_reg};
        end
        sw_tilt = (st_sum >= ST_W'(TILT_HIGH_MRAD)) ? TILT_W'(TILT_LOW_MRAD)
                                                    : st_sum[TILT_W-1:0];

        // Tracking correction added to the last goal, then clamped to the head limits.
        pan_sum  = SUM_W'(goal_pan_reg) + SUM_W'(item.pan_corr);
        tilt_sum = signed'(SUM_W'({1'b0, goal_tilt_reg})) + SUM_W'(item.tilt_corr);
        if (pan_sum > SUM_W'(PAN_LIMIT_MRAD)) begin
            pan_clamped = PAN_W'(PAN_LIMIT_MRAD);
        end else if (pan_sum < -SUM_W'(PAN_LIMIT_MRAD)) begin
            pan_clamped = -PAN_W'(PAN_LIMIT_MRAD);
        end else begin
            pan_clamped = pan_sum[PAN_W-1:0];
        end
        if (tilt_sum > SUM_W'(TILT_HIGH_MRAD)) begin
            tilt_clamped = TILT_W'(TILT_HIGH_MRAD);
        end else if (tilt_sum < SUM_W'(TILT_LOW_MRAD)) begin
            tilt_clamped = TILT_W'(TILT_LOW_MRAD);
        end else begin
            tilt_clamped = tilt_sum[TILT_W-1:0];
        end

        mode_next       = mode_reg;
        ticks_next      = tick_inc;
        sweep_pan_next  = sweep_pan_reg;
        sweep_tilt_next = sweep_tilt_reg;
        rising_next     = rising_reg;
        goal_pan_next   = goal_pan_reg;
        goal_tilt_next  = goal_tilt_reg;
        has_result      = 1'b0;
        from_search     = 1'b0;

        if (item.kind) begin
            ticks_next = '0;
            mode_next  = MODE_TRACK;
            if (item.corr_en) begin
                goal_pan_next  = pan_clamped;
                goal_tilt_next = tilt_clamped;
                has_result     = 1'b1;
            end
        end else begin
            case (mode_reg)
                MODE_TRACK: begin
                    if (timed_out) begin
                        mode_next = MODE_LOST;
                    end
                end
                MODE_LOST: begin
                    if (lost_done) begin
                        mode_next = MODE_SEARCH;
                    end
                end
                default: begin
                    mode_next = MODE_SEARCH;
                    if (timed_out) begin
                        sweep_pan_next  = sw_pan;
                        sweep_tilt_next = sw_tilt;
                        rising_next     = sw_rising;
                        goal_pan_next   = sw_pan;
                        goal_tilt_next  = sw_tilt;
                        has_result      = 1'b1;
                        from_search     = 1'b1;
                    end
                end
            endcase
        end
    end

    // An item that yields no result never waits on the result register.
    assign advance = item_valid && (!has_result || !m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_SEARCH;
            ticks_reg      <= '0;
            sweep_pan_reg  <= -PAN_W'(PAN_LIMIT_MRAD);
            sweep_tilt_reg <= TILT_W'(TILT_LOW_MRAD);
            rising_reg     <= 1'b1;
            goal_pan_reg   <= '0;
            goal_tilt_reg  <= TILT_W'(TILT_LOW_MRAD);
            m_valid_reg    <= 1'b0;
        end else begin
            if (advance) begin
                mode_reg       <= mode_next;
                ticks_reg      <= ticks_next;
                sweep_pan_reg  <= sweep_pan_next;
                sweep_tilt_reg <= sweep_tilt_next;
                rising_reg     <= rising_next;
                goal_pan_reg   <= goal_pan_next;
                goal_tilt_reg  <= goal_tilt_next;
            end
            if (advance && has_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && has_result) begin
            m_data_reg.pan_goal    <= goal_pan_next;
            m_data_reg.tilt_goal   <= goal_tilt_next;
            m_data_reg.from_search <= from_search;
            m_data_reg.mode        <= mode_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pan_tilt_search_track_controller.sv
// Pan/tilt search-and-track controller: top level.
// Usage: each s_ transaction is a tick (kind 0) or a detection (kind 1) with pixel
// position and confidence. The block keeps a searching, tracking or lost mode and a tick
// counter; search ticks past the timeout step a pan sweep, confident detections add a
// rounded proportional correction to the last goal. Each item yields zero or one m_
// transaction carrying pan and tilt goals in milliradians, the source and the new mode.
// Configuration writes on cfg_ are always taken (cfg_ready is high) and must be issued
// only while no item is in flight.
// On acceptance the gain multiplications run on the incoming transaction and the input
// register takes the rounded corrections; the state update then loads the result
// register, which is held off while a full result register waits on m_ready. Throughput
// is one item per cycle unless that result register stalls, set by the single
// state-update stage whose goal and sweep registers feed back each cycle.
// Reset (aresetn low, synchronous) restores the register defaults, searching mode, a
// zero tick counter, the sweep at the negative pan limit and lowest tilt.
// When m_ready is low the result register holds; items that produce no result still
// pass, and input is stalled only when a result-producing item finds it full.
`timescale 1ns / 1ps
`default_nettype none

module pan_tilt_search_track_controller
    import ptstc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_t                   s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_t                       m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  advance;

    ptstc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ptstc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg        (cfg),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ptstc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire
